/* rtl/stnco_pkg.sv */
// ---------------------------------------------------------------------------
// Sine table NCO package
// Shared sizes, register indexes, reset values and the sine table builder.
// ---------------------------------------------------------------------------
package stnco_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);

    localparam int FREQ_W     = 25;
    localparam int RATE_W     = 18;
    localparam int PHASE_W    = 32;
    localparam int FRAC_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int INC_SHIFT  = 24;
    localparam int DIVIDEND_W = FREQ_W + INC_SHIFT;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_RATE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NYQUIST     = 1'd1;

    localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = 18'd48000;
    localparam logic [FREQ_W-1:0] NYQUIST_RESET     = 25'd6144000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] SINE_PEAK   = 64'd32767;

    // Taylor series divisors (2k)(2k+1) for k = 1 .. 10.
    localparam logic [63:0] TAYLOR_DIV [1:10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
          64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef logic signed [SAMPLE_W-1:0] t_rom [TABLE_SIZE];

    // sin(pi/2 * t / TABLE_SIZE) in Q30, for 0 <= t <= TABLE_SIZE.
    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] t);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (t * HALF_PI_Q30) / TABLE_SIZE;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int k = 1; k <= 10; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if ((k % 2) == 1) begin
                sum = (sum >= term) ? (sum - term) : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // One full sine cycle built from the quarter wave by symmetry.
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] four_i;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] t;
        logic [63:0] mag;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            four_i = 64'(4 * i);
            quad   = four_i / TABLE_SIZE;
            rem    = four_i % TABLE_SIZE;
            t      = quad[0] ? (64'(TABLE_SIZE) - rem) : rem;
            mag    = (quarter_sine_q30(t) * SINE_PEAK + (ONE_Q30 >> 1)) >> 30;
            if (mag > SINE_PEAK) begin
                mag = SINE_PEAK;
            end
            rom[i] = quad[1] ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
        end
        return rom;
    endfunction

endpackage

/* rtl/stnco_div.sv */
// ---------------------------------------------------------------------------
// Sine table NCO phase increment divider
// Restoring divider, one quotient bit per cycle; keeps the low 32 bits.
// ---------------------------------------------------------------------------
module stnco_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [stnco_pkg::DIVIDEND_W-1:0]    i_dividend,
    input  logic [stnco_pkg::RATE_W-1:0]        i_divisor,
    output logic                                o_done,
    output logic [stnco_pkg::PHASE_W-1:0]       o_quot
);

    logic                                   r_busy;
    logic                                   r_done;
    logic [stnco_pkg::DIV_CNT_W-1:0]        r_cnt;
    logic [stnco_pkg::DIVIDEND_W-1:0]       r_num;
    logic [stnco_pkg::RATE_W-1:0]           r_den;
    logic [stnco_pkg::RATE_W-1:0]           r_rem;
    logic [stnco_pkg::PHASE_W-1:0]          r_quot;

    logic [stnco_pkg::RATE_W:0]             trial;
    logic [stnco_pkg::RATE_W:0]             diff;
    logic                                   fits;

    assign trial = {r_rem, r_num[stnco_pkg::DIVIDEND_W-1]};
    assign fits  = (trial >= {1'b0, r_den});
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == stnco_pkg::DIV_CNT_W'(stnco_pkg::DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[stnco_pkg::DIVIDEND_W-2:0], 1'b0};
            r_rem  <= fits ? diff[stnco_pkg::RATE_W-1:0] : trial[stnco_pkg::RATE_W-1:0];
            r_quot <= {r_quot[stnco_pkg::PHASE_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/stnco_rom.sv */
// ---------------------------------------------------------------------------
// Sine table NCO sine ROM
// One full sine cycle in Q1.15 with a registered read port.
// ---------------------------------------------------------------------------
module stnco_rom (
    input  logic                                i_clk,
    input  logic [stnco_pkg::ADDR_W-1:0]        i_addr,
    output logic signed [stnco_pkg::SAMPLE_W-1:0] o_data
);

    localparam stnco_pkg::t_rom SINE_ROM = stnco_pkg::build_rom();

    logic signed [stnco_pkg::SAMPLE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

/* rtl/sine_table_nco_unit.sv */
// ---------------------------------------------------------------------------
// Sine table NCO
// Direct digital synthesis sine oscillator with linear interpolation.
// ---------------------------------------------------------------------------
// Each input word is a frequency in 1/256 Hz. It is clamped to the Nyquist
// limit register, turned into a 32-bit phase increment
// floor(freq * 2^24 / sample_rate_hz) and added to a wrapping phase
// accumulator; a sample rate of zero gives no increment. The top ten phase
// bits address a 1024-entry Q1.15 sine ROM, the next 16 bits are the
// interpolation fraction, and the entry after the last one is entry zero.
// One output word, the interpolated sample rounded to nearest, follows every
// input word. For each word the phase increment is worked out by a
// bit-serial restoring divider that needs 49 steps, followed by two ROM
// reads on the single ROM port, one multiply and one rounding add. The input
// side is ready only while the block is idle; a finished sample waits in an
// output register, so the next word can be taken before it is consumed.
// Configuration writes are to be made only while the block is idle.
// ---------------------------------------------------------------------------
module sine_table_nco_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [24:0] freq, [31:25] zero

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] sample

    input  logic                                i_cfg_we,
    input  logic [stnco_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [stnco_pkg::FREQ_W-1:0]        i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a word
    localparam logic [2:0] S_DIV  = 3'd1;  // divider running
    localparam logic [2:0] S_ADDR = 3'd2;  // ROM reads the lower entry
    localparam logic [2:0] S_NEXT = 3'd3;  // ROM reads the upper entry
    localparam logic [2:0] S_MUL  = 3'd4;  // difference times fraction
    localparam logic [2:0] S_RND  = 3'd5;  // add, then hand to output

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Configuration registers.
    logic [stnco_pkg::RATE_W-1:0]   r_sample_rate;
    logic [stnco_pkg::FREQ_W-1:0]   r_nyquist;

    // Datapath registers.
    logic [stnco_pkg::PHASE_W-1:0]          r_phase;
    logic signed [stnco_pkg::SAMPLE_W-1:0]  r_lo;
    logic signed [33:0]                     r_prod;
    logic                                   r_out_valid;
    logic [stnco_pkg::SAMPLE_W-1:0]         r_out_data;

    logic                                   accept;
    logic [stnco_pkg::FREQ_W-1:0]           freq;
    logic [stnco_pkg::FREQ_W-1:0]           freq_clamped;
    logic                                   div_done;
    logic [stnco_pkg::PHASE_W-1:0]          div_quot;
    logic [stnco_pkg::ADDR_W-1:0]           idx;
    logic [stnco_pkg::ADDR_W-1:0]           rom_addr;
    logic [stnco_pkg::FRAC_W-1:0]           frac;
    logic signed [stnco_pkg::SAMPLE_W-1:0]  rom_data;
    logic signed [stnco_pkg::SAMPLE_W:0]    diff;
    logic signed [33:0]                     prod;
    logic                                   out_load;

    // The block works on one word at a time.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Requests above the limit run at the limit.
    assign freq         = i_s_axis_tdata[stnco_pkg::FREQ_W-1:0];
    assign freq_clamped = (freq > r_nyquist) ? r_nyquist : freq;

    stnco_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend ({freq_clamped, {stnco_pkg::INC_SHIFT{1'b0}}}),
        .i_divisor  (r_sample_rate),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Table index and fraction come straight from the top of the phase.
    // The upper entry address wraps from the last entry to entry zero.
    assign idx      = r_phase[stnco_pkg::PHASE_W-1 -: stnco_pkg::ADDR_W];
    assign frac     = r_phase[stnco_pkg::PHASE_W-stnco_pkg::ADDR_W-1 -: stnco_pkg::FRAC_W];
    assign rom_addr = (r_state == S_NEXT) ? (idx + 1'b1) : idx;

    stnco_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // In S_MUL the ROM output holds the upper entry. The half LSB offset is
    // folded in here, so an arithmetic shift later rounds to nearest with
    // ties toward plus infinity.
    assign diff = {rom_data[stnco_pkg::SAMPLE_W-1], rom_data}
                - {r_lo[stnco_pkg::SAMPLE_W-1], r_lo};
    assign prod = 34'(diff * $signed({1'b0, frac})) + 34'sd32768;

    // The result enters the output register once the register is free or
    // is being emptied in the same cycle.
    assign out_load = (r_state == S_RND) && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_state = S_NEXT;
            end
            S_NEXT: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_RND;
            end
            S_RND: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, configuration, the phase accumulator and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_sample_rate <= stnco_pkg::SAMPLE_RATE_RESET;
            r_nyquist     <= stnco_pkg::NYQUIST_RESET;
            r_phase       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    stnco_pkg::CFG_SAMPLE_RATE: begin
                        r_sample_rate <= i_cfg_data[stnco_pkg::RATE_W-1:0];
                    end
                    stnco_pkg::CFG_NYQUIST: begin
                        r_nyquist <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            // A zero sample rate leaves the phase where it is.
            if ((r_state == S_DIV) && div_done && (r_sample_rate != '0)) begin
                r_phase <= r_phase + div_quot;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_NEXT) begin
            r_lo <= rom_data;
        end
        if (r_state == S_MUL) begin
            r_prod <= prod;
        end
        if (out_load) begin
            r_out_data <= r_lo + r_prod[stnco_pkg::SAMPLE_W+15:16];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sine table NCO testbench
// Streams frequency words into the oscillator under several register settings
// and stall patterns, and checks every sample against a local NCO predictor.
// ---------------------------------------------------------------------------
module tb_top;

    // -----------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // -----------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;   // [24:0] freq, [31:25] zero

    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;         // [15:0] sample

    logic                              i_cfg_we    = 1'b0;
    logic [stnco_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [stnco_pkg::FREQ_W-1:0]      i_cfg_data  = '0;

    always #5 i_clk = ~i_clk;

    sine_table_nco_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // -----------------------------------------------------------------------
    // Predictor state: the oscillator's registers, its phase and the table.
    // -----------------------------------------------------------------------
    logic        [stnco_pkg::RATE_W-1:0]   rate_m;
    logic        [stnco_pkg::FREQ_W-1:0]   limit_m;
    logic        [stnco_pkg::PHASE_W-1:0]  phase_m;
    logic signed [stnco_pkg::SAMPLE_W-1:0] sine_tab [stnco_pkg::TABLE_SIZE];

    logic [stnco_pkg::FREQ_W-1:0]          freq_q[$];        // words waiting to be offered
    logic signed [stnco_pkg::SAMPLE_W-1:0] sample_exp_q[$];  // samples owed by the DUT

    int  err_count  = 0;
    int  idle_pct   = 0;   // percent of cycles the sender holds back
    int  stall_pct  = 0;   // percent of cycles the receiver holds back
    int  hold_left  = 0;
    bit  hold_req   = 1'b0;
    bit  in_fire    = 1'b0;

    // Sine of (pi/2 * t / TABLE_SIZE) as a Q30 value, from a Taylor series in fixed
    // point up to the x^21 term. Terms for odd k are subtracted with a floor at zero.
    function automatic longint unsigned quarter_wave_q30(longint unsigned t);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned acc;
        ang    = (t * 64'd1686629713) / 64'(stnco_pkg::TABLE_SIZE);
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = ang;
        for (int k = 1; k <= 10; k++) begin
            term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = (acc >= term) ? acc - term : 64'd0;
            end else begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    // Fill the whole cycle from the quarter wave. Odd quadrants run the
    // quarter wave backwards; the second half of the cycle is negated.
    function automatic void fill_sine_tab();
        longint unsigned quadrant;
        longint unsigned offs;
        longint unsigned mag;
        for (int i = 0; i < stnco_pkg::TABLE_SIZE; i++) begin
            quadrant = (4 * i) / stnco_pkg::TABLE_SIZE;
            offs     = (4 * i) % stnco_pkg::TABLE_SIZE;
            if (quadrant[0]) begin
                offs = stnco_pkg::TABLE_SIZE - offs;
            end
            mag = (quarter_wave_q30(offs) * 64'd32767 + 64'd536870912) >> 30;
            if (mag > 64'd32767) begin
                mag = 64'd32767;
            end
            sine_tab[i] = quadrant[1] ? -16'(mag) : 16'(mag);
        end
    endfunction

    // Advance the phase by one frequency word and return the interpolated
    // sample. The increment is truncated, the phase wraps modulo one turn,
    // and the interpolation step rounds half up via an arithmetic shift.
    function automatic logic signed [stnco_pkg::SAMPLE_W-1:0] nco_advance(
            logic [stnco_pkg::FREQ_W-1:0] freq);
        logic        [stnco_pkg::FREQ_W-1:0]     f_clamped;
        logic        [stnco_pkg::DIVIDEND_W-1:0] step;
        logic        [stnco_pkg::ADDR_W-1:0]     idx;
        logic        [stnco_pkg::ADDR_W-1:0]     idx_next;
        logic        [stnco_pkg::FRAC_W-1:0]     frac;
        logic signed [16:0]                      diff;
        logic signed [35:0]                      prod;
        logic signed [35:0]                      interp;
        f_clamped = (freq > limit_m) ? limit_m : freq;
        step      = (rate_m != '0) ? ({f_clamped, 24'd0} / rate_m) : '0;
        phase_m   = phase_m + step[stnco_pkg::PHASE_W-1:0];
        idx       = phase_m[stnco_pkg::PHASE_W-1 -: stnco_pkg::ADDR_W];
        frac      = phase_m[stnco_pkg::PHASE_W-stnco_pkg::ADDR_W-1 -: stnco_pkg::FRAC_W];
        idx_next  = idx + 1'b1;   // the last entry is followed by entry zero
        diff      = sine_tab[idx_next] - sine_tab[idx];
        prod      = diff * $signed({1'b0, frac}) + 36'sd32768;
        interp    = sine_tab[idx] + (prod >>> 16);
        return interp[stnco_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic flag_mismatch(string what);
        $display("ERROR @%0t: %s", $realtime, what);
        err_count++;
    endtask

    // -----------------------------------------------------------------------
    // Input side. Acceptance is sampled at the rising edge; the expected
    // sample is computed right there, in acceptance order.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (in_fire) begin
            sample_exp_q.push_back(nco_advance(i_s_axis_tdata[stnco_pkg::FREQ_W-1:0]));
        end
    end

    // Driver: a word stays on the bus until taken; after that the next one
    // is offered, unless the sender chooses to idle this cycle.
    always @(negedge i_clk) begin
        if (!i_s_axis_tvalid || in_fire) begin
            if (freq_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {7'd0, freq_q.pop_front()};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Output side. The long hold-off is counted in its own process so the
    // sender keeps pushing while the output is blocked.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 500;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Monitor: every accepted sample must match the oldest expectation.
    always @(posedge i_clk) begin
        logic signed [stnco_pkg::SAMPLE_W-1:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (sample_exp_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected sample %0d",
                                        $signed(o_m_axis_tdata)));
            end else begin
                want = sample_exp_q.pop_front();
                if (o_m_axis_tdata !== want) begin
                    flag_mismatch($sformatf("sample got %0d want %0d",
                                            $signed(o_m_axis_tdata), want));
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequencing helpers.
    // -----------------------------------------------------------------------
    task automatic write_reg(logic [stnco_pkg::CFG_INDEX_W-1:0] index,
                             logic [stnco_pkg::FREQ_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        if (index == stnco_pkg::CFG_SAMPLE_RATE) begin
            rate_m = value[stnco_pkg::RATE_W-1:0];
        end else if (index == stnco_pkg::CFG_NYQUIST) begin
            limit_m = value;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Block goes idle once all words are taken and all samples are back;
    // then allow a full item time before touching the registers.
    task automatic wait_idle();
        while (freq_q.size() > 0 || i_s_axis_tvalid || sample_exp_q.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (64) @(negedge i_clk);
    endtask

    // Random frequency words: mostly the legal range, some full-width words
    // to exercise every input bit, and some right at the clamp boundary.
    function automatic logic [stnco_pkg::FREQ_W-1:0] pick_freq();
        case ($urandom_range(9))
            0, 1:    return stnco_pkg::FREQ_W'($urandom);
            2:       return stnco_pkg::FREQ_W'(limit_m
                         + stnco_pkg::FREQ_W'($urandom_range(4)) - 25'd2);
            3:       return stnco_pkg::FREQ_W'($urandom_range(255));
            default: return stnco_pkg::FREQ_W'($urandom_range(25600000));
        endcase
    endfunction

    task automatic run_random(int count, int src_idle, int snk_stall);
        idle_pct  = src_idle;
        stall_pct = snk_stall;
        repeat (count) freq_q.push_back(pick_freq());
        wait_idle();
    endtask

    // -----------------------------------------------------------------------
    // Main sequence.
    // -----------------------------------------------------------------------
    initial begin
        fill_sine_tab();
        rate_m  = stnco_pkg::SAMPLE_RATE_RESET;
        limit_m = stnco_pkg::NYQUIST_RESET;
        phase_m = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings (48 kHz, limit 6144000). The
        // limit gives exactly half a turn per word; 3072000 is a quarter
        // turn, and 3071999 lands just short of a full turn, so its own sample
        // interpolates from the last table entry across the wrap.
        // Words above the limit, including all-ones, get clamped.
        freq_q = '{25'd0, 25'd1, 25'd6144000, 25'd3072000, 25'd3071999,
                   25'd3072000, 25'd6144001, 25'h1FFFFFF, 25'd25600000,
                   25'h0AAAAAA, 25'h1555555, 25'd12345, 25'd768000,
                   25'd768000, 25'd1536000, 25'd1536001, 25'd3, 25'd47999,
                   25'd48000, 25'd6143999, 25'd0};
        wait_idle();

        // No idling, plus one long receiver hold-off so the input backs up.
        @(negedge i_clk);
        hold_req = 1'b1;
        run_random(200, 0, 0);

        // Highest legal rate and limit.
        write_reg(stnco_pkg::CFG_SAMPLE_RATE, 25'd192000);
        write_reg(stnco_pkg::CFG_NYQUIST, 25'd25600000);
        run_random(200, 66, 0);

        // Limit of zero: every word is clamped to nothing, the phase holds.
        write_reg(stnco_pkg::CFG_SAMPLE_RATE, 25'd8000);
        write_reg(stnco_pkg::CFG_NYQUIST, 25'd0);
        run_random(100, 0, 66);

        // Zero sample rate: no increment at all.
        write_reg(stnco_pkg::CFG_SAMPLE_RATE, 25'd0);
        write_reg(stnco_pkg::CFG_NYQUIST, 25'h1FFFFFF);
        run_random(100, 31, 31);

        // Rate of one: increments far beyond a turn, only the low bits count.
        write_reg(stnco_pkg::CFG_SAMPLE_RATE, 25'd1);
        run_random(150, 0, 0);

        write_reg(stnco_pkg::CFG_SAMPLE_RATE, 25'd44100);
        write_reg(stnco_pkg::CFG_NYQUIST, 25'd5644800);
        run_random(150, 66, 0);

        // All-ones rate field.
        write_reg(stnco_pkg::CFG_SAMPLE_RATE, 25'd262143);
        write_reg(stnco_pkg::CFG_NYQUIST, 25'h1FFFFFF);
        run_random(150, 0, 66);

        write_reg(stnco_pkg::CFG_SAMPLE_RATE, 25'd8000);
        write_reg(stnco_pkg::CFG_NYQUIST, 25'd25600000);
        run_random(150, 31, 31);

        if (sample_exp_q.size() != 0) begin
            flag_mismatch($sformatf("%0d samples never arrived", sample_exp_q.size()));
        end
        if (err_count == 0) begin
            $display("sine_table_nco_unit verification clean");
        end else begin
            $display("sine_table_nco_unit verification failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("sine_table_nco_unit verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/stnco_pkg.sv
rtl/stnco_div.sv
rtl/stnco_rom.sv
rtl/sine_table_nco_unit.sv
tb/tb_top.sv
